@@ rtl/core/mm64_pkg.sv @@
// Shared constants, state encoding and small helpers for the MurmurHash64A block.
// No dependencies; used by mm64_mul and murmur64a_message_hash.
package mm64_pkg;

  localparam logic [63:0] MURMUR_MULT = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT   = 47;

  localparam logic [31:0] MULT_LO = MURMUR_MULT[31:0];
  localparam logic [31:0] MULT_HI = MURMUR_MULT[63:32];

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_SEED     = 7'b0000100,
    S_KMIX1    = 7'b0001000,
    S_KMIX2    = 7'b0010000,
    S_HMUL     = 7'b0100000,
    S_FINAL    = 7'b1000000
  } state_e;

  // Keep the low nb bytes of a word.
  function automatic logic [63:0] tail_mask(input logic [2:0] nb);
    logic [63:0] mask;
    mask = '0;
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = (3'(i) < nb) ? 8'hFF : 8'h00;
    end
    return mask;
  endfunction

  function automatic logic [63:0] xor_shift(input logic [63:0] x);
    return x ^ (x >> MIX_SHIFT);
  endfunction

endpackage

@@ rtl/core/mm64_mul.sv @@
// Iterative 64-bit multiply by the MurmurHash constant, low 64 bits of the product.
// One 32x32 multiplier reused over three partial products; uses mm64_pkg.
module mm64_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] operand_i,
  output logic        done_o,
  output logic [63:0] product_o
);

  logic [63:0] a_q, a_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] prod_q, prod_d;
  logic [1:0]  step_q, step_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] mul_a, mul_b;

  // Operand select for the shared multiplier.
  always_comb begin
    unique case (step_q)
      2'd0: begin
        mul_a = a_q[31:0];
        mul_b = mm64_pkg::MULT_LO;
      end
      2'd1: begin
        mul_a = a_q[31:0];
        mul_b = mm64_pkg::MULT_HI;
      end
      2'd2: begin
        mul_a = a_q[63:32];
        mul_b = mm64_pkg::MULT_LO;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    a_d    = a_q;
    acc_d  = acc_q;
    prod_d = {32'b0, mul_a} * {32'b0, mul_b};
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = operand_i;
      step_d = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      step_d = step_q + 2'd1;
      unique case (step_q)
        2'd0: acc_d = acc_q;
        2'd1: acc_d = prod_q;
        2'd2: acc_d = acc_q + {prod_q[31:0], 32'b0};
        default: begin
          // cross terms only reach the upper half
          acc_d  = acc_q + {prod_q[31:0], 32'b0};
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("multiplier done while still busy");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier started while busy");

  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && step_q == 2'd3) |=> done_q)
    else $error("multiplier missed its done pulse");

endmodule

@@ rtl/core/murmur64a_message_hash.sv @@
// MurmurHash64A over a message streamed as little-endian 64-bit words: one beat per word,
// the first beat seeds from hash_seed and the length, the last beat emits the hash.
// Every 64-bit multiply runs on one shared 32x32 multiplier, and a beat runs these:
// 1 to seed on a first beat, 3 for a full word or 1 for a tail, 1 for the final mix on
// a last beat. The input stalls until the beat is done; a finished hash waits in the
// output register while the next beat is taken, and the final mix holds only while
// that register is full and stalled.
// Depends on mm64_pkg and mm64_mul.
module murmur64a_message_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               hash_seed_we_i,
  input  logic signed [31:0] hash_seed_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               first_word_i,
  input  logic [30:0]        message_length_i,
  input  logic [63:0]        data_word_i,
  input  logic [3:0]         valid_bytes_i,
  input  logic               last_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [63:0]        hash_value_o
);

  mm64_pkg::state_e state_q, state_d;

  logic [31:0] seed_q;
  logic [63:0] h_q, h_d;
  logic        first_q, last_q;
  logic [30:0] len_q;
  logic [63:0] word_q;
  logic [3:0]  nb_q;
  logic        out_valid_q, out_valid_d;
  logic [63:0] hash_q;
  logic        out_load;
  logic        in_take;

  logic        mul_start;
  logic [63:0] mul_operand;
  logic        mul_done;
  logic [63:0] mul_product;

  logic [63:0]      h_base;
  logic             abs_start;
  logic [63:0]      abs_operand;
  mm64_pkg::state_e abs_next;

  // Multiplier result is final once its done pulse has been seen in this state.
  logic u_mul_busy;
  logic fin_seen_q, fin_seen_d;

  mm64_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .operand_i (mul_operand),
    .done_o    (mul_done),
    .product_o (mul_product)
  );

  assign in_stall_o = (state_q != mm64_pkg::S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;

  // Hash entering the absorb step: freshly seeded or carried over.
  assign h_base = (state_q == mm64_pkg::S_SEED)
                ? ({{32{seed_q[31]}}, seed_q} ^ mul_product) : h_q;

  always_comb begin
    if (nb_q[3]) begin
      abs_start   = 1'b1;
      abs_operand = word_q;
      abs_next    = mm64_pkg::S_KMIX1;
    end else if (nb_q[2:0] != 3'd0) begin
      abs_start   = 1'b1;
      abs_operand = h_base ^ (word_q & mm64_pkg::tail_mask(nb_q[2:0]));
      abs_next    = mm64_pkg::S_HMUL;
    end else if (last_q) begin
      abs_start   = 1'b1;
      abs_operand = mm64_pkg::xor_shift(h_base);
      abs_next    = mm64_pkg::S_FINAL;
    end else begin
      abs_start   = 1'b0;
      abs_operand = '0;
      abs_next    = mm64_pkg::S_IDLE;
    end
  end

  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    mul_start   = 1'b0;
    mul_operand = '0;
    out_load    = 1'b0;
    unique case (state_q)
      mm64_pkg::S_IDLE: begin
        if (in_take) begin
          state_d = mm64_pkg::S_DISPATCH;
        end
      end
      mm64_pkg::S_DISPATCH: begin
        if (first_q) begin
          mul_start   = 1'b1;
          mul_operand = {33'b0, len_q};
          state_d     = mm64_pkg::S_SEED;
        end else begin
          mul_start   = abs_start;
          mul_operand = abs_operand;
          state_d     = abs_next;
        end
      end
      mm64_pkg::S_SEED: begin
        if (mul_done) begin
          h_d         = h_base;
          mul_start   = abs_start;
          mul_operand = abs_operand;
          state_d     = abs_next;
        end
      end
      mm64_pkg::S_KMIX1: begin
        if (mul_done) begin
          mul_start   = 1'b1;
          mul_operand = mm64_pkg::xor_shift(mul_product);
          state_d     = mm64_pkg::S_KMIX2;
        end
      end
      mm64_pkg::S_KMIX2: begin
        if (mul_done) begin
          mul_start   = 1'b1;
          mul_operand = h_q ^ mul_product;
          state_d     = mm64_pkg::S_HMUL;
        end
      end
      mm64_pkg::S_HMUL: begin
        if (mul_done) begin
          h_d = mul_product;
          if (last_q) begin
            mul_start   = 1'b1;
            mul_operand = mm64_pkg::xor_shift(mul_product);
            state_d     = mm64_pkg::S_FINAL;
          end else begin
            state_d = mm64_pkg::S_IDLE;
          end
        end
      end
      mm64_pkg::S_FINAL: begin
        // product holds until the next start, so wait here for a free output slot
        if (mul_done || !out_valid_q || !out_stall_i) begin
          if (!out_valid_q || !out_stall_i) begin
            if (!u_mul_busy) begin
              out_load = 1'b1;
              state_d  = mm64_pkg::S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = mm64_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    fin_seen_d = fin_seen_q;
    if (mul_start) begin
      fin_seen_d = 1'b0;
    end else if (mul_done) begin
      fin_seen_d = 1'b1;
    end
  end

  assign u_mul_busy = !(fin_seen_q || mul_done);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mm64_pkg::S_IDLE;
      seed_q      <= '0;
      h_q         <= '0;
      out_valid_q <= 1'b0;
      fin_seen_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      out_valid_q <= out_valid_d;
      fin_seen_q  <= fin_seen_d;
      if (hash_seed_we_i) begin
        seed_q <= hash_seed_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      first_q <= first_word_i;
      len_q   <= message_length_i;
      word_q  <= data_word_i;
      nb_q    <= valid_bytes_i;
      last_q  <= last_word_i;
    end
    if (out_load) begin
      hash_q <= mm64_pkg::xor_shift(mul_product);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  a_take_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q == mm64_pkg::S_DISPATCH))
    else $error("accepted beat did not reach dispatch");

  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == mm64_pkg::S_SEED || state_q == mm64_pkg::S_KMIX1 ||
                  state_q == mm64_pkg::S_KMIX2 || state_q == mm64_pkg::S_HMUL ||
                  state_q == mm64_pkg::S_FINAL))
    else $error("multiply finished with no state waiting on it");

  a_load_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == mm64_pkg::S_FINAL && last_q))
    else $error("hash loaded outside the final mix of a last beat");

endmodule

@@ tb/sv/murmur64a_hash_checker.sv @@
`timescale 1ns / 1ps
// Checker for murmur64a_message_hash: follows the seed register and both channels,
// predicts each message hash and compares it with the emitted one. Depends on mm64_pkg.
module murmur64a_hash_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               hash_seed_we_i,
  input  logic signed [31:0] hash_seed_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               first_word_i,
  input  logic [30:0]        message_length_i,
  input  logic [63:0]        data_word_i,
  input  logic [3:0]         valid_bytes_i,
  input  logic               last_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [63:0]        hash_value_i,
  output int                 fail_count_o,
  output int                 pending_count_o
);

  logic signed [31:0] seed_q;
  logic [63:0]        chain_hash;
  logic [63:0]        pending_hashes[$];

  // Absorb one beat: 8 or more bytes is a full word, 1 to 7 a low-byte tail.
  function automatic logic [63:0] fold_beat(input logic [63:0] h, input logic [63:0] w,
                                            input logic [3:0] nb);
    logic [63:0] k;
    if (nb[3]) begin
      k = w * mm64_pkg::MURMUR_MULT;
      k = k ^ (k >> mm64_pkg::MIX_SHIFT);
      k = k * mm64_pkg::MURMUR_MULT;
      h = (h ^ k) * mm64_pkg::MURMUR_MULT;
    end else if (nb != 4'd0) begin
      h = (h ^ (w & ((64'd1 << (8 * nb)) - 64'd1))) * mm64_pkg::MURMUR_MULT;
    end
    return h;
  endfunction

  function automatic logic [63:0] finish_hash(input logic [63:0] h);
    h = h ^ (h >> mm64_pkg::MIX_SHIFT);
    h = h * mm64_pkg::MURMUR_MULT;
    return h ^ (h >> mm64_pkg::MIX_SHIFT);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] want;
    if (!rst_ni) begin
      seed_q = '0;
      chain_hash = '0;
      pending_hashes.delete();
      pending_count_o = 0;
    end else begin
      if (hash_seed_we_i) begin
        seed_q = hash_seed_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (first_word_i) begin
          chain_hash = {{32{seed_q[31]}}, seed_q} ^
                       ({33'd0, message_length_i} * mm64_pkg::MURMUR_MULT);
        end
        chain_hash = fold_beat(chain_hash, data_word_i, valid_bytes_i);
        if (last_word_i) begin
          pending_hashes = {pending_hashes, finish_hash(chain_hash)};
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_hashes.size() == 0) begin
          $display("%0t: unexpected hash beat, expected none, got %h", $time, hash_value_i);
          fail_count_o++;
        end else begin
          want = pending_hashes.pop_front();
          if (hash_value_i !== want) begin
            $display("%0t: hash_value mismatch, expected %h, got %h", $time, want, hash_value_i);
            fail_count_o++;
          end
        end
      end
      pending_count_o = pending_hashes.size();
    end
  end

endmodule

@@ tb/sv/tb_murmur64a_message_hash.sv @@
`timescale 1ns / 1ps
// Top of the murmur64a_message_hash testbench: clock, reset, seed writes, message
// stimulus and stall patterns; the verdict comes from murmur64a_hash_checker.
module tb_murmur64a_message_hash;

  localparam int PHASE_COUNT     = 6;
  localparam int BEATS_PER_PHASE = 225;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 1000000;

  logic               clk_i;
  logic               rst_ni;
  logic               hash_seed_we_i;
  logic signed [31:0] hash_seed_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               first_word_i;
  logic [30:0]        message_length_i;
  logic [63:0]        data_word_i;
  logic [3:0]         valid_bytes_i;
  logic               last_word_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [63:0]        hash_value_o;

  logic in_fire_q;
  int   fail_count;
  int   pending_count;
  int   beats_sent;
  int   gap_pct;
  int   stall_pct;
  int   cycle_count;

  murmur64a_message_hash dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .hash_seed_we_i   (hash_seed_we_i),
    .hash_seed_i      (hash_seed_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .first_word_i     (first_word_i),
    .message_length_i (message_length_i),
    .data_word_i      (data_word_i),
    .valid_bytes_i    (valid_bytes_i),
    .last_word_i      (last_word_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hash_value_o     (hash_value_o)
  );

  murmur64a_hash_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .hash_seed_we_i   (hash_seed_we_i),
    .hash_seed_i      (hash_seed_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .first_word_i     (first_word_i),
    .message_length_i (message_length_i),
    .data_word_i      (data_word_i),
    .valid_bytes_i    (valid_bytes_i),
    .last_word_i      (last_word_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hash_value_i     (hash_value_o),
    .fail_count_o     (fail_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    in_fire_q <= in_valid_i && !in_stall_o;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Hold the beat until it is taken; valid stays high for a back-to-back beat.
  task automatic send_beat(input logic first, input logic [30:0] len, input logic [63:0] data,
                           input logic [3:0] nb, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    first_word_i     <= first;
    message_length_i <= len;
    data_word_i      <= data;
    valid_bytes_i    <= nb;
    last_word_i      <= last;
    do @(negedge clk_i); while (!in_fire_q);
    beats_sent++;
  endtask

  // Well-formed message: length beat first, full words, tail or full word last; an empty message is one empty beat.
  task automatic send_message(input int unsigned nbytes);
    int unsigned beats;
    int unsigned left;
    beats = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
    left  = nbytes;
    for (int b = 0; b < beats; b++) begin
      send_beat(b == 0, 31'(nbytes), rand_word(), (left >= 8) ? 4'd8 : 4'(left),
                b == beats - 1);
      left = (left >= 8) ? left - 8 : 0;
    end
  endtask

  // Length is random and need not agree with the words, start mark sometimes missing.
  task automatic send_broken_message();
    int beats;
    beats = $urandom_range(1, 4);
    for (int b = 0; b < beats; b++) begin
      send_beat((b == 0) && ($urandom_range(3) != 0), 31'($urandom), rand_word(),
                (b == beats - 1) ? 4'($urandom_range(15)) : 4'd8, b == beats - 1);
    end
  endtask

  // Drop valid, let all hashes come out and the block settle before a seed write.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_seed(input logic signed [31:0] seed);
    hash_seed_we_i <= 1'b1;
    hash_seed_i    <= seed;
    @(negedge clk_i);
    hash_seed_we_i <= 1'b0;
  endtask

  task automatic send_directed();
    send_beat(1'b0, 31'd0, rand_word(), 4'd8, 1'b1);  // no start mark, hash from reset
    send_beat(1'b1, 31'd0, 64'd0, 4'd0, 1'b1);
    send_beat(1'b1, 31'd8, '1, 4'd8, 1'b1);
    send_beat(1'b1, 31'h7FFF_FFFF, '1, 4'd15, 1'b1);
    send_beat(1'b1, 31'd7, '1, 4'd7, 1'b1);
    send_beat(1'b1, 31'd1, 64'hFFFF_FFFF_FFFF_FF5A, 4'd1, 1'b1);
    send_beat(1'b1, 31'd11, rand_word(), 4'd8, 1'b0);
    send_beat(1'b0, 31'h7FFF_FFFF, rand_word(), 4'd3, 1'b1);
    send_beat(1'b0, 31'd0, rand_word(), 4'd5, 1'b1);  // extend past the end
    send_beat(1'b0, 31'd0, rand_word(), 4'd9, 1'b0);
    send_beat(1'b0, 31'd0, rand_word(), 4'd0, 1'b1);
    send_beat(1'b1, 31'd10, rand_word(), 4'd2, 1'b0); // short word mid-message
    send_beat(1'b0, 31'd0, rand_word(), 4'd8, 1'b1);
    send_beat(1'b1, 31'd16, rand_word(), 4'd8, 1'b0);
    send_beat(1'b0, 31'd0, rand_word(), 4'd0, 1'b0);
    send_beat(1'b0, 31'd0, rand_word(), 4'd12, 1'b1);
    send_beat(1'b1, 31'd3, rand_word(), 4'd3, 1'b0);  // restart before the last beat
    send_beat(1'b1, 31'd5, rand_word(), 4'd5, 1'b1);
  endtask

  initial begin
    logic signed [31:0] phase_seed[PHASE_COUNT];
    int                 pick;
    int                 goal;
    phase_seed[0] = 32'sh8000_0000;
    phase_seed[1] = 32'sh7FFF_FFFF;
    phase_seed[2] = 32'sh0000_0000;
    phase_seed[3] = -32'sd1;
    phase_seed[4] = $urandom;
    phase_seed[5] = $urandom;
    rst_ni           = 1'b0;
    hash_seed_we_i   = 1'b0;
    hash_seed_i      = '0;
    in_valid_i       = 1'b0;
    first_word_i     = 1'b0;
    message_length_i = '0;
    data_word_i      = '0;
    valid_bytes_i    = '0;
    last_word_i      = 1'b0;
    out_stall_i      = 1'b0;
    gap_pct          = 0;
    stall_pct        = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase != 0) begin
        wait_idle();
      end
      write_seed(phase_seed[phase]);
      gap_pct   = (phase < 2) ? 14 : (phase < 4) ? 74 : 0;
      stall_pct = (phase < 2) ? 74 : (phase < 4) ? 14 : 0;
      if (phase == 0) begin
        send_directed();
      end
      goal = beats_sent + BEATS_PER_PHASE;
      while (beats_sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          pick = $urandom_range(99);
          send_message((pick < 80) ? $urandom_range(40) :
                       (pick < 95) ? $urandom_range(160, 41) : $urandom_range(400, 161));
        end else if (pick < 85) begin
          send_broken_message();
        end else begin
          send_beat(1'($urandom_range(1)), 31'($urandom), rand_word(),
                    4'($urandom_range(15)), 1'($urandom_range(1)));
        end
      end
    end

    stall_pct = 0;
    wait_idle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
